[rtl/core/bce_pkg.sv]
package bce_pkg;

    // fixed field widths
    localparam int COORD_W    = 32;
    localparam int BLEND_W    = 19;
    localparam int BLEND_FRAC = 16;
    localparam int SEG_W      = 9;
    localparam int MAX_POINTS = 256;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int COUNT_W    = PT_W + 1;
    localparam int NAXES      = 3;
    localparam int SLOT_W     = 2;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COUNT_W;

    // lerp datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + BLEND_W;
    localparam int RND_W  = PROD_W - BLEND_FRAC;
    localparam int SUM_W  = RND_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [BLEND_W-1:0] t_blend;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef enum logic [1:0] {
        MODE_CONST  = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_BEZIER = 2'd2
    } t_mode;

    localparam logic              KIND_WRITE = 1'b0;
    localparam logic              KIND_EVAL  = 1'b1;
    localparam logic [SLOT_W-1:0] SLOT_POS   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_HIN   = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_HOUT  = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam t_blend BLEND_ONE  = t_blend'(1) <<< BLEND_FRAC;
    localparam t_blend BLEND_ZERO = '0;
    localparam t_coord COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_prod  RND_UP     = t_prod'(1) <<< (BLEND_FRAC - 1);
    localparam t_prod  RND_DN     = RND_UP - t_prod'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTS);

    // (b - a) * t, full precision
    function automatic t_prod f_mul(t_coord a, t_coord b, t_blend t);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(b) - DIFF_W'(a);
        // zero blend gives zero even for operands that were never loaded
        if (t == BLEND_ZERO) begin
            return '0;
        end
        return t_prod'(d * t);
    endfunction

    // a + round(p / 2^frac), ties away from zero, saturated
    function automatic t_coord f_fin(t_coord a, t_prod p);
        t_prod                     pr;
        logic signed [RND_W-1:0]   r;
        logic signed [SUM_W-1:0]   s;
        logic [SUM_W-COORD_W:0]    top;
        pr  = p + (p[PROD_W-1] ? RND_DN : RND_UP);
        r   = RND_W'(pr >>> BLEND_FRAC);
        s   = SUM_W'(a) + SUM_W'(r);
        top = s[SUM_W-1:COORD_W-1];
        if ((&top) || (~|top)) begin
            return s[COORD_W-1:0];
        end
        return s[SUM_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

endpackage

[rtl/core/bce_if.sv]
interface bce_in_if
    import bce_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [PT_W-1:0]       write_index;
    logic [SLOT_W-1:0]     slot;
    logic [AXIS_W-1:0]     axis;
    logic signed [COORD_W-1:0] coord_value;
    logic signed [SEG_W-1:0]   segment;
    logic signed [BLEND_W-1:0] blend;

    modport source (output valid, kind, write_index, slot, axis, coord_value, segment, blend,
                    input ready);
    modport sink   (input valid, kind, write_index, slot, axis, coord_value, segment, blend,
                    output ready);
endinterface

interface bce_out_if
    import bce_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

interface bce_cfg_if
    import bce_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/bezier_curve_3d_evaluator.sv]
// Channel   Dir  Beat                                        Ready
// i_in      in   write one coordinate, or evaluate segment    stage-1 slot free
// o_out     out  evaluated x, y, z (Q16.16, saturated)        from sink
// i_cfg     in   register index + data (mode, point count)    always high
//
// Seven-stage pipeline, one evaluate beat per cycle while o_out is not stalled.
// Depth is set by the three de Casteljau levels, each a multiply stage and a
// round/add/saturate stage, behind a registered memory read in stage 1.
// Write beats update the coordinate memories at the accept edge and give no result.
// Reset (i_rst_n low, synchronous) clears valids, mode to bezier and count to zero;
// memory contents are undefined until written.
// Stages hold independently: bubbles collapse, so input keeps flowing while a
// finished result waits on o_out, until every stage is full.
module bezier_curve_3d_evaluator
    import bce_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    bce_in_if.sink        i_in,
    bce_out_if.source     o_out,
    bce_cfg_if.sink       i_cfg
);

    localparam int NSTG = 7;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    t_mode              r_mode;
    logic [COUNT_W-1:0] r_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BEZIER;
            r_count <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_MODE) begin
                r_mode <= t_mode'(i_cfg.data[1:0]);
            end else if (i_cfg.index == CFG_COUNT) begin
                r_count <= i_cfg.data[COUNT_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: a stage loads when empty or when it drains
    // ---------------------------------------------------------------
    logic [NSTG:1] r_v;
    logic [NSTG:1] n_v;
    logic [NSTG:1] w_rdy;

    always_comb begin
        w_rdy[NSTG] = !r_v[NSTG] || o_out.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    logic w_acc, w_wr, w_ev;
    assign i_in.ready = w_rdy[1];
    assign w_acc      = i_in.valid && w_rdy[1];
    assign w_wr       = w_acc && (i_in.kind == KIND_WRITE);
    assign w_ev       = w_acc && (i_in.kind == KIND_EVAL);

    always_comb begin
        n_v = r_v;
        if (w_rdy[1]) begin
            n_v[1] = w_ev;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (w_rdy[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // ---------------------------------------------------------------
    // coordinate memories, one per store and axis
    // ---------------------------------------------------------------
    t_coord r_pos_mem  [NAXES][MAX_POINTS];
    t_coord r_hin_mem  [NAXES][MAX_POINTS];
    t_coord r_hout_mem [NAXES][MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (w_wr && (i_in.axis <= AXIS_LAST)) begin
            unique case (i_in.slot)
                SLOT_POS:  r_pos_mem[i_in.axis][i_in.write_index]  <= i_in.coord_value;
                SLOT_HIN:  r_hin_mem[i_in.axis][i_in.write_index]  <= i_in.coord_value;
                SLOT_HOUT: r_hout_mem[i_in.axis][i_in.write_index] <= i_in.coord_value;
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // address and blend decode of the incoming beat
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] w_cnt, w_last;
    logic               w_neg, w_past, w_pass, w_lin, w_bez, w_empty;
    logic [PT_W-1:0]    w_p0, w_p1;
    t_blend             w_tclamp, w_t1, w_t23;

    always_comb begin
        w_cnt   = (r_count > COUNT_MAX) ? COUNT_MAX : r_count;
        w_empty = (w_cnt == '0);
        w_last  = w_cnt - COUNT_W'(1);
        w_neg   = i_in.segment[SEG_W-1];
        w_past  = !w_neg && ({1'b0, i_in.segment[PT_W-1:0]} >= w_last);
        // out-of-range segments and constant mode just return one position
        w_pass  = w_neg || w_past || (r_mode == MODE_CONST);
        w_lin   = !w_pass && (r_mode == MODE_LINEAR);
        w_bez   = !w_pass && !w_lin;
        if (w_neg) begin
            w_p0 = '0;
        end else if (w_past) begin
            w_p0 = w_last[PT_W-1:0];
        end else begin
            w_p0 = i_in.segment[PT_W-1:0];
        end
        w_p1 = w_p0 + PT_W'(1);
        if (i_in.blend <= BLEND_ZERO) begin
            w_tclamp = BLEND_ZERO;
        end else if (i_in.blend >= BLEND_ONE) begin
            w_tclamp = BLEND_ONE;
        end else begin
            w_tclamp = i_in.blend;
        end
        // a lerp with t = 0 passes its first operand exactly, so linear and
        // constant results fall through the later levels untouched
        w_t1  = w_pass ? BLEND_ZERO : (w_lin ? w_tclamp : i_in.blend);
        w_t23 = w_bez ? i_in.blend : BLEND_ZERO;
    end

    // ---------------------------------------------------------------
    // stage 1: memory read
    // ---------------------------------------------------------------
    t_coord r1_a [NAXES];
    t_coord r1_b [NAXES];
    t_coord r1_c [NAXES];
    t_coord r1_d [NAXES];
    t_blend r1_t1, r1_t2, r1_t3;
    logic   r1_lin, r1_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int ax = 0; ax < NAXES; ax++) begin
                r1_a[ax] <= r_pos_mem[ax][w_p0];
                r1_b[ax] <= r_hout_mem[ax][w_p0];
                r1_c[ax] <= r_hin_mem[ax][w_p1];
                r1_d[ax] <= r_pos_mem[ax][w_p1];
            end
            r1_t1   <= w_t1;
            r1_t2   <= w_t23;
            r1_t3   <= w_t23;
            r1_lin  <= w_lin;
            r1_zero <= w_empty;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: level-1 multiplies (linear mode lerps a..d in lane 0)
    // ---------------------------------------------------------------
    t_coord r2_a [3][NAXES];
    t_prod  r2_p [3][NAXES];
    t_blend r2_t2, r2_t3;
    logic   r2_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int ax = 0; ax < NAXES; ax++) begin
                r2_a[0][ax] <= r1_a[ax];
                r2_a[1][ax] <= r1_b[ax];
                r2_a[2][ax] <= r1_c[ax];
                r2_p[0][ax] <= f_mul(r1_a[ax], r1_lin ? r1_d[ax] : r1_b[ax], r1_t1);
                r2_p[1][ax] <= f_mul(r1_b[ax], r1_c[ax], r1_t1);
                r2_p[2][ax] <= f_mul(r1_c[ax], r1_d[ax], r1_t1);
            end
            r2_t2   <= r1_t2;
            r2_t3   <= r1_t3;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: level-1 round, add, saturate
    t_coord r3_q [3][NAXES];
    t_blend r3_t2, r3_t3;
    logic   r3_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int ln = 0; ln < 3; ln++) begin
                for (int ax = 0; ax < NAXES; ax++) begin
                    r3_q[ln][ax] <= f_fin(r2_a[ln][ax], r2_p[ln][ax]);
                end
            end
            r3_t2   <= r2_t2;
            r3_t3   <= r2_t3;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: level-2 multiplies
    t_coord r4_a [2][NAXES];
    t_prod  r4_p [2][NAXES];
    t_blend r4_t3;
    logic   r4_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            for (int ln = 0; ln < 2; ln++) begin
                for (int ax = 0; ax < NAXES; ax++) begin
                    r4_a[ln][ax] <= r3_q[ln][ax];
                    r4_p[ln][ax] <= f_mul(r3_q[ln][ax], r3_q[ln+1][ax], r3_t2);
                end
            end
            r4_t3   <= r3_t3;
            r4_zero <= r3_zero;
        end
    end

    // stage 5: level-2 round, add, saturate
    t_coord r5_r [2][NAXES];
    t_blend r5_t3;
    logic   r5_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            for (int ln = 0; ln < 2; ln++) begin
                for (int ax = 0; ax < NAXES; ax++) begin
                    r5_r[ln][ax] <= f_fin(r4_a[ln][ax], r4_p[ln][ax]);
                end
            end
            r5_t3   <= r4_t3;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: level-3 multiply
    t_coord r6_a [NAXES];
    t_prod  r6_p [NAXES];
    logic   r6_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            for (int ax = 0; ax < NAXES; ax++) begin
                r6_a[ax] <= r5_r[0][ax];
                r6_p[ax] <= f_mul(r5_r[0][ax], r5_r[1][ax], r5_t3);
            end
            r6_zero <= r5_zero;
        end
    end

    // stage 7: final round/add/saturate (zero for an empty curve), doubles as the output register
    t_coord r7_res [NAXES];

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            for (int ax = 0; ax < NAXES; ax++) begin
                r7_res[ax] <= r6_zero ? '0 : f_fin(r6_a[ax], r6_p[ax]);
            end
        end
    end

    assign o_out.valid = r_v[NSTG];
    assign o_out.out_x = r7_res[0];
    assign o_out.out_y = r7_res[1];
    assign o_out.out_z = r7_res[2];

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !r_v[1])
        else $error("write beat entered the pipeline");

    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev |=> r_v[1])
        else $error("evaluate beat lost at stage 1");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !o_out.ready) |-> !i_in.ready)
        else $error("full stalled pipeline still accepting");

    a_linear_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r1_lin) |-> (r1_t1 >= BLEND_ZERO && r1_t1 <= BLEND_ONE
                                && r1_t2 == BLEND_ZERO && r1_t3 == BLEND_ZERO))
        else $error("linear blend not clamped or later levels active");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !w_rdy[4]) |=> r_v[4])
        else $error("stalled stage dropped its item");
`endif

endmodule

[verif/bezier_curve_3d_evaluator_tb.sv]
module bezier_curve_3d_evaluator_tb;
    import bce_pkg::*;

    // Clock, pipeline depth, and how long we wait before giving up.
    localparam int HALF_PERIOD = 5;
    localparam int PIPE_LAT    = 6;      // accept edge to o_out.valid, stage 1 through stage 7
    localparam int QUIET_WAIT  = PIPE_LAT + 5;
    localparam int SINK_HOLD   = 60;     // long receiver stall, in cycles
    localparam int IDLE_LIMIT  = 4000;   // cycles with no beat anywhere before we bail
    localparam int MAX_REPORTS = 100;
    localparam int LOAD_POINTS = 64;     // low points loaded; the last two are loaded too

    // Field codes that the package leaves unnamed.
    localparam logic [1:0]        MODE_SPARE = 2'd3;  // unused mode, must act as bezier
    localparam logic [SLOT_W-1:0] SLOT_SPARE = 2'd3;  // write dropped
    localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;  // write dropped

    // One input beat, all fields always driven.
    typedef struct {
        logic                  kind;
        logic [PT_W-1:0]       widx;
        logic [SLOT_W-1:0]     slot;
        logic [AXIS_W-1:0]     axis;
        t_coord                value;
        logic signed [SEG_W-1:0] seg;
        t_blend                t;
    } t_beat;

    // One evaluated xyz point.
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    logic i_clk;
    logic i_rst_n;

    bce_in_if  bus_in  ();
    bce_out_if bus_out ();
    bce_cfg_if bus_cfg ();

    bezier_curve_3d_evaluator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bus_in),
        .o_out   (bus_out),
        .i_cfg   (bus_cfg)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: coordinate stores and both registers.
    // Updated from the accepted beats only, so it tracks the DUT's view.
    // ------------------------------------------------------------------
    t_coord                pos_mem  [MAX_POINTS*NAXES];
    t_coord                hin_mem  [MAX_POINTS*NAXES];
    t_coord                hout_mem [MAX_POINTS*NAXES];
    logic [1:0]            cfg_mode;
    logic [COUNT_W-1:0]    cfg_count;

    // Points still owed by the DUT, oldest first.
    t_point pending_points [$];

    int src_idle_pct;
    int sink_idle_pct;
    logic sink_hold;
    event sink_stall_go;

    int n_evals    = 0;
    int n_writes   = 0;
    int n_checked  = 0;
    int n_mismatch = 0;
    int idle_cycles;

    always #HALF_PERIOD i_clk = ~i_clk;

    // a + round((b - a) * t / one), ties away from zero, clamped to Q16.16.
    function automatic t_coord lerp_q16(t_coord a, t_coord b, t_blend t);
        longint span;
        longint mag;
        longint frac;
        longint step;
        longint total;
        span  = longint'(b) - longint'(a);
        mag   = (span < 0) ? -span : span;
        frac  = (t < 0) ? -longint'(t) : longint'(t);
        step  = (mag * frac + (longint'(1) <<< (BLEND_FRAC - 1))) >>> BLEND_FRAC;
        if ((span < 0) != (t < 0))
            step = -step;
        total = longint'(a) + step;
        if (total > longint'(COORD_MAX))
            return COORD_MAX;
        if (total < longint'(COORD_MIN))
            return COORD_MIN;
        return t_coord'(total);
    endfunction

    // Point on the curve for one evaluate beat under the current registers.
    function automatic t_point curve_point(logic signed [SEG_W-1:0] seg, t_blend t);
        t_coord xyz [NAXES];
        t_coord a, b, c, d;
        t_coord q1, q2, q3, r1, r2;
        int n;
        int s;
        int p;
        n = (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
        s = seg;
        for (int ax = 0; ax < NAXES; ax++)
            xyz[ax] = '0;
        if (n != 0) begin
            if (s < 0 || s >= n - 1 || cfg_mode == MODE_CONST) begin
                // clamp to first / last point, or plain lookup in constant mode
                p = (s < 0) ? 0 : ((s >= n - 1) ? n - 1 : s);
                for (int ax = 0; ax < NAXES; ax++)
                    xyz[ax] = pos_mem[p*NAXES + ax];
            end else begin
                for (int ax = 0; ax < NAXES; ax++) begin
                    a = pos_mem[s*NAXES + ax];
                    d = pos_mem[(s+1)*NAXES + ax];
                    if (cfg_mode == MODE_LINEAR) begin
                        if (t <= 0)
                            xyz[ax] = a;
                        else if (t >= BLEND_ONE)
                            xyz[ax] = d;
                        else
                            xyz[ax] = lerp_q16(a, d, t);
                    end else begin
                        // bezier, also for the spare mode; blend not clamped
                        b  = hout_mem[s*NAXES + ax];
                        c  = hin_mem[(s+1)*NAXES + ax];
                        q1 = lerp_q16(a, b, t);
                        q2 = lerp_q16(b, c, t);
                        q3 = lerp_q16(c, d, t);
                        r1 = lerp_q16(q1, q2, t);
                        r2 = lerp_q16(q2, q3, t);
                        xyz[ax] = lerp_q16(r1, r2, t);
                    end
                end
            end
        end
        return '{xyz[0], xyz[1], xyz[2]};
    endfunction

    task automatic flag_mismatch(string msg);
        if (n_mismatch < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        n_mismatch++;
    endtask

    // ------------------------------------------------------------------
    // Checker, shadow update and watchdog, all on one edge so the order
    // of output check, input prediction and register update is fixed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        logic   moved;
        int     entry;
        if (!i_rst_n) begin
            idle_cycles = 0;
            cfg_mode    = MODE_BEZIER;
            cfg_count   = '0;
        end else begin
            moved = 1'b0;
            if (bus_out.valid && bus_out.ready) begin
                moved = 1'b1;
                got   = '{bus_out.out_x, bus_out.out_y, bus_out.out_z};
                if (pending_points.size() == 0) begin
                    flag_mismatch($sformatf("unexpected point %h %h %h",
                                            got.x, got.y, got.z));
                end else begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x)
                        flag_mismatch($sformatf("point %0d x: got %h expected %h",
                                                n_checked, got.x, want.x));
                    if (got.y !== want.y)
                        flag_mismatch($sformatf("point %0d y: got %h expected %h",
                                                n_checked, got.y, want.y));
                    if (got.z !== want.z)
                        flag_mismatch($sformatf("point %0d z: got %h expected %h",
                                                n_checked, got.z, want.z));
                    n_checked++;
                end
            end
            if (bus_in.valid && bus_in.ready) begin
                moved = 1'b1;
                if (bus_in.kind == KIND_WRITE) begin
                    n_writes++;
                    // slot 3 or axis 3 is dropped by the block
                    if (bus_in.slot <= SLOT_HOUT && bus_in.axis <= AXIS_LAST) begin
                        entry = bus_in.write_index * NAXES + bus_in.axis;
                        case (bus_in.slot)
                            SLOT_POS: pos_mem[entry]  = bus_in.coord_value;
                            SLOT_HIN: hin_mem[entry]  = bus_in.coord_value;
                            default:  hout_mem[entry] = bus_in.coord_value;
                        endcase
                    end
                end else begin
                    n_evals++;
                    pending_points.push_back(curve_point(bus_in.segment, bus_in.blend));
                end
            end
            if (bus_cfg.valid && bus_cfg.ready) begin
                moved = 1'b1;
                if (bus_cfg.index == CFG_MODE)
                    cfg_mode = bus_cfg.data[1:0];
                else if (bus_cfg.index == CFG_COUNT)
                    cfg_count = bus_cfg.data;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d points outstanding",
                         IDLE_LIMIT, pending_points.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: random ready, forced low while a long stall is running.
    always @(posedge i_clk) begin
        if (sink_hold)
            bus_out.ready <= 1'b0;
        else
            bus_out.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Long receiver stall, counted here so the sender keeps going meanwhile.
    initial begin
        sink_hold = 1'b0;
        forever begin
            @(sink_stall_go);
            sink_hold <= 1'b1;
            repeat (SINK_HOLD) @(posedge i_clk);
            sink_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3, 4: return t_coord'(int'($urandom_range(2097151)) - 1048576);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Coordinate write; evaluate fields carry noise.
    function automatic t_beat coord_beat(int idx, logic [SLOT_W-1:0] slot,
                                         logic [AXIS_W-1:0] axis, t_coord value);
        t_beat b;
        b.kind  = KIND_WRITE;
        b.widx  = PT_W'(idx);
        b.slot  = slot;
        b.axis  = axis;
        b.value = value;
        b.seg   = SEG_W'($urandom);
        b.t     = BLEND_W'($urandom);
        return b;
    endfunction

    // Evaluate; write fields carry noise.
    function automatic t_beat eval_beat(int seg, int t);
        t_beat b;
        b.kind  = KIND_EVAL;
        b.widx  = PT_W'($urandom);
        b.slot  = SLOT_W'($urandom);
        b.axis  = AXIS_W'($urandom);
        b.value = t_coord'($urandom);
        b.seg   = SEG_W'(seg);
        b.t     = BLEND_W'(t);
        return b;
    endfunction

    // Mostly evaluates on loaded segments, the rest writes and odd segments.
    function automatic t_beat rand_beat();
        int n;
        int seg;
        t_blend t;
        logic [SLOT_W-1:0] slot;
        logic [AXIS_W-1:0] axis;
        n = (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
        if ($urandom_range(99) < 25) begin
            slot = ($urandom_range(99) < 8) ? SLOT_W'($urandom_range(3))
                                             : SLOT_W'($urandom_range(2));
            axis = ($urandom_range(99) < 8) ? AXIS_W'($urandom_range(3))
                                             : AXIS_W'($urandom_range(2));
            return coord_beat($urandom_range(MAX_POINTS - 1), slot, axis, rand_coord());
        end
        // in-range segments stay on loaded points; past the end hits the last one
        if (n >= 2 && $urandom_range(99) < 80)
            seg = $urandom_range(((n < LOAD_POINTS) ? n : LOAD_POINTS) - 2);
        else if (n >= 1 && $urandom_range(1) == 0)
            seg = $urandom_range(255, n - 1);
        else
            seg = -int'($urandom_range(256, 1));
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(5))
                    0:       t = BLEND_ZERO;
                    1:       t = BLEND_ONE;
                    2:       t = -BLEND_ONE;
                    3:       t = {1'b0, {(BLEND_W-1){1'b1}}};
                    4:       t = {1'b1, {(BLEND_W-1){1'b0}}};
                    default: t = BLEND_ONE <<< 1;
                endcase
            end
            1, 2:    t = t_blend'($urandom);
            default: t = t_blend'($urandom_range(BLEND_ONE));
        endcase
        return eval_beat(seg, t);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one beat after a random gap and hold it until accepted.
    task automatic send_beat(t_beat b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            bus_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        bus_in.valid       <= 1'b1;
        bus_in.kind        <= b.kind;
        bus_in.write_index <= b.widx;
        bus_in.slot        <= b.slot;
        bus_in.axis        <= b.axis;
        bus_in.coord_value <= b.value;
        bus_in.segment     <= b.seg;
        bus_in.blend       <= b.t;
        do @(posedge i_clk); while (!bus_in.ready);
    endtask

    // Sender goes quiet until every owed point has come back.
    task automatic wait_drained();
        bus_in.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Drained, then a further quiet wait with the sender idle.
    task automatic settle();
        wait_drained();
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    // Registers only change with the block idle.
    task automatic set_config(logic [1:0] mode, int count);
        settle();
        bus_cfg.valid <= 1'b1;
        bus_cfg.index <= CFG_MODE;
        bus_cfg.data  <= CFG_DATA_W'(mode);
        do @(posedge i_clk); while (!bus_cfg.ready);
        bus_cfg.index <= CFG_COUNT;
        bus_cfg.data  <= CFG_DATA_W'(count);
        do @(posedge i_clk); while (!bus_cfg.ready);
        bus_cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset leaves the count at zero: every evaluate returns the origin,
    // and no stored value reaches the result, so this runs before anything is loaded.
    task automatic test_empty_curve();
        send_beat(eval_beat(-1, 0));
        send_beat(eval_beat(0, 32768));
        send_beat(eval_beat(255, 65536));
        settle();
    endtask

    // Fill every slot of the low points and of the last two; evaluates
    // only ever land on those points.
    task automatic test_load_curve();
        int p;
        for (int k = 0; k < LOAD_POINTS + 2; k++) begin
            p = (k < LOAD_POINTS) ? k : MAX_POINTS - (LOAD_POINTS + 2) + k;
            for (int sl = 0; sl <= SLOT_HOUT; sl++)
                for (int ax = 0; ax <= AXIS_LAST; ax++)
                    send_beat(coord_beat(p, SLOT_W'(sl), AXIS_W'(ax), rand_coord()));
        end
        settle();
    endtask

    task automatic test_special_cases();
        // constant mode, and a negative segment falling back to point 0
        set_config(MODE_CONST, 4);
        send_beat(eval_beat(1, 32768));
        send_beat(eval_beat(-1, 32768));
        // linear blend clamps at both ends; segments past the end give the last point
        set_config(MODE_LINEAR, 4);
        send_beat(eval_beat(1, -65536));
        send_beat(eval_beat(1, 0));
        send_beat(eval_beat(1, 1));
        send_beat(eval_beat(1, 65536));
        send_beat(eval_beat(1, 131072));
        send_beat(eval_beat(-256, 32768));
        send_beat(eval_beat(3, 32768));
        send_beat(eval_beat(255, 0));
        // bezier, inside and outside the unit blend
        set_config(MODE_BEZIER, 4);
        send_beat(eval_beat(2, 65536));
        send_beat(eval_beat(2, 32768));
        send_beat(eval_beat(2, -65536));
        send_beat(eval_beat(2, 131072));
        // opposite extremes on segment 0 x, then drive extrapolation into saturation
        send_beat(coord_beat(0, SLOT_POS, AXIS_X, COORD_MAX));
        send_beat(coord_beat(0, SLOT_HOUT, AXIS_X, COORD_MIN));
        send_beat(coord_beat(1, SLOT_HIN, AXIS_X, COORD_MAX));
        send_beat(coord_beat(1, SLOT_POS, AXIS_X, COORD_MIN));
        // malformed writes must leave point 0 alone
        send_beat(coord_beat(0, SLOT_SPARE, AXIS_X, '0));
        send_beat(coord_beat(0, SLOT_POS, AXIS_SPARE, '0));
        send_beat(eval_beat(0, 262143));
        send_beat(eval_beat(0, -262144));
        set_config(MODE_SPARE, 4);
        send_beat(eval_beat(0, 49152));
        set_config(MODE_CONST, 4);
        send_beat(eval_beat(0, 0));
        // counts above the table size act as the full table
        set_config(MODE_BEZIER, 300);
        send_beat(eval_beat(255, 0));
        send_beat(eval_beat(254, 16384));
        set_config(MODE_LINEAR, 511);
        send_beat(eval_beat(-1, 0));
        // one and two point curves
        set_config(MODE_BEZIER, 1);
        send_beat(eval_beat(0, 32768));
        set_config(MODE_LINEAR, 2);
        send_beat(eval_beat(0, 32768));
        send_beat(eval_beat(1, 0));
        settle();
    endtask

    // Receiver stalls for a long stretch while the sender streams back to
    // back, so the pipeline fills and i_in.ready has to drop.
    task automatic test_full_backpressure();
        int saved_pct;
        saved_pct = src_idle_pct;
        set_config(MODE_BEZIER, MAX_POINTS);
        src_idle_pct = 0;
        -> sink_stall_go;
        repeat (40) send_beat(eval_beat($urandom_range(LOAD_POINTS - 2),
                                        $urandom_range(BLEND_ONE)));
        src_idle_pct = saved_pct;
        settle();
    endtask

    // Sender pauses mid-stream until the pipeline is empty, then resumes.
    task automatic test_drain_pause();
        set_config(MODE_LINEAR, 64);
        repeat (12) send_beat(rand_beat());
        wait_drained();
        repeat (12) send_beat(rand_beat());
        settle();
    endtask

    // Mixed traffic over several register settings at one idling mix.
    task automatic test_random_traffic(int src_pct, int sink_pct);
        int count;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(7))
                0:       count = 0;
                1:       count = 1;
                2:       count = 2;
                3:       count = MAX_POINTS;
                4:       count = (1 << COUNT_W) - 1;
                default: count = $urandom_range(64, 3);
            endcase
            set_config(2'($urandom_range(3)), count);
            repeat (30) send_beat(rand_beat());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        bus_in.valid        = 1'b0;
        bus_in.kind         = KIND_WRITE;
        bus_in.write_index  = '0;
        bus_in.slot         = SLOT_POS;
        bus_in.axis         = AXIS_X;
        bus_in.coord_value  = '0;
        bus_in.segment      = '0;
        bus_in.blend        = '0;
        bus_cfg.valid       = 1'b0;
        bus_cfg.index       = CFG_MODE;
        bus_cfg.data        = '0;
        src_idle_pct        = 21;
        sink_idle_pct       = 55;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_curve();
        test_load_curve();
        test_special_cases();
        test_full_backpressure();
        test_drain_pause();
        test_random_traffic(21, 55);
        test_random_traffic(55, 21);
        test_random_traffic(0, 0);

        settle();
        if (pending_points.size() != 0)
            flag_mismatch($sformatf("%0d points never came out", pending_points.size()));

        $display("run: %0d evaluate beats, %0d coordinate writes, %0d points checked",
                 n_evals, n_writes, n_checked);
        $display("run: constant, linear, bezier and spare modes, empty to oversize curves, "
                 , "%0d mismatches", n_mismatch);
        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
